@@ rtl/rpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpfc_pkg
// Shared types, constants and helpers for the robot packet framer / checker.
// ----------------------------------------------------------------------------
package rpfc_pkg;

    localparam int MAX_BODY        = 253;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int POS_W           = 9;
    localparam int NUM_SLOTS       = 7;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_FIRST  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_SECOND = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'd250;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd251;

    localparam logic MODE_FRAME   = 1'b0;
    localparam logic MODE_VERIFY  = 1'b1;
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [NUM_SLOTS-1:0] SLOT_HDR0    = 7'b000_0001;
    localparam logic [NUM_SLOTS-1:0] SLOT_HDR1    = 7'b000_0010;
    localparam logic [NUM_SLOTS-1:0] SLOT_HDR2    = 7'b000_0100;
    localparam logic [NUM_SLOTS-1:0] SLOT_BODY    = 7'b000_1000;
    localparam logic [NUM_SLOTS-1:0] SLOT_CSUM_HI = 7'b001_0000;
    localparam logic [NUM_SLOTS-1:0] SLOT_CSUM_LO = 7'b010_0000;
    localparam logic [NUM_SLOTS-1:0] SLOT_VERDICT = 7'b100_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] body_length;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       out_last;
        logic       check_ok;
    } out_item_t;

    typedef struct packed {
        logic        hdr;
        logic        body;
        logic        csum;
        logic        verdict;
        logic        ok;
        logic [7:0]  len_byte;
        logic [7:0]  data;
        logic [15:0] csum_val;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } sync_cfg_t;

    function automatic logic [NUM_SLOTS-1:0] cmd_mask(input cmd_t c);
        cmd_mask = {c.verdict, c.csum, c.csum, c.body, c.hdr, c.hdr, c.hdr};
    endfunction

endpackage

@@ rtl/robot_packet_framer_checker.sv @@
// ----------------------------------------------------------------------------
// robot_packet_framer_checker
// Byte-serial packet framer (mode 0) and received-packet checker (mode 1)
// with a 16-bit big-endian word-sum checksum.
//
//   port group  direction  transaction
//   s_*         in         one packet or body byte (data_byte, body_length)
//   m_*         out        one framed byte or one verdict
//   cfg_*       in         register write, index 0 mode, 1/2 sync bytes
//
// Input takes one transaction per cycle while the command queue has room.
// Output gives one result per cycle while m_ready is high; a frame of N
// body bytes yields N + 5 results, so the output port sets the sustained
// frame-mode rate. A command passes the queue, the back part's command
// register and the output register before its first result. Queue holds
// QUEUE_DEPTH commands (2 or more); synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module robot_packet_framer_checker import rpfc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      mode_reg;
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic      mode_wr;
    sync_cfg_t sync_cfg;
    cmd_push_t push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    cmd_t      q_head;

    assign mode_wr              = cfg_wr_en && (cfg_addr == CFG_MODE);
    assign sync_cfg.sync_first  = sync_first_reg;
    assign sync_cfg.sync_second = sync_second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_FRAME;
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MODE:        mode_reg        <= cfg_wdata[0];
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    rpfc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mode    (mode_reg),
        .mode_wr (mode_wr),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push)
    );

    rpfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    rpfc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sync_cfg (sync_cfg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/rpfc_front.sv @@
// ----------------------------------------------------------------------------
// rpfc_front
// Takes input bytes, tracks packet position and checksum, and queues one
// output command per input transaction that produces results.
// ----------------------------------------------------------------------------
module rpfc_front import rpfc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      mode,
    input  logic      mode_wr,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    input  logic      q_full,
    output cmd_push_t push
);

    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       held_reg, held_next;
    logic             pend_reg, pend_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       plen_reg, plen_next;
    logic [7:0]       rch_reg, rch_next;

    logic             accept;
    logic [7:0]       b;
    logic [7:0]       len_clamp;
    logic             first;
    logic             clear_base;
    logic [15:0]      base_sum;
    logic [7:0]       base_held;
    logic             base_pend;
    logic [15:0]      t_sum;
    logic [7:0]       t_held;
    logic             t_pend;
    logic [15:0]      fin_cur;
    logic [15:0]      t_fin;
    logic [7:0]       eff_len;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] plen_ext;

    assign s_ready = !q_full;

    always_comb begin
        accept    = s_valid && !q_full;
        b         = s_data.data_byte;
        if (s_data.body_length == 8'd0) begin
            len_clamp = 8'd1;
        end else if (s_data.body_length > 8'(MAX_BODY)) begin
            len_clamp = 8'(MAX_BODY);
        end else begin
            len_clamp = s_data.body_length;
        end
        first      = (pos_reg == '0);
        plen_ext   = {1'b0, plen_reg};
        pos_inc    = pos_reg + POS_W'(1);
        clear_base = (mode == MODE_FRAME) && first;
        base_sum   = clear_base ? 16'h0000 : sum_reg;
        base_held  = clear_base ? 8'h00 : held_reg;
        base_pend  = clear_base ? 1'b0 : pend_reg;
        if (base_pend) begin
            t_sum  = base_sum + {base_held, b};
            t_held = base_held;
            t_pend = 1'b0;
        end else begin
            t_sum  = base_sum;
            t_held = b;
            t_pend = 1'b1;
        end
        fin_cur = sum_reg ^ {8'h00, (pend_reg ? held_reg : 8'h00)};
        t_fin   = t_sum ^ {8'h00, (t_pend ? t_held : 8'h00)};
        eff_len = first ? len_clamp : plen_reg;

        sum_next  = sum_reg;
        held_next = held_reg;
        pend_next = pend_reg;
        pos_next  = pos_reg;
        plen_next = plen_reg;
        rch_next  = rch_reg;
        push      = '0;

        if (mode_wr) begin
            pos_next = '0;
        end else if (accept) begin
            if (mode == MODE_FRAME) begin
                push.valid = 1'b1;
                if (!first && pos_reg >= plen_ext) begin
                    push.cmd.csum     = 1'b1;
                    push.cmd.csum_val = fin_cur;
                    pos_next          = '0;
                end else begin
                    if (first) begin
                        plen_next         = len_clamp;
                        push.cmd.hdr      = 1'b1;
                        push.cmd.len_byte = len_clamp + 8'd2;
                    end
                    sum_next      = t_sum;
                    held_next     = t_held;
                    pend_next     = t_pend;
                    push.cmd.body = 1'b1;
                    push.cmd.data = b;
                    if (!first && pos_inc >= {1'b0, eff_len}) begin
                        push.cmd.csum     = 1'b1;
                        push.cmd.csum_val = t_fin;
                        pos_next          = '0;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end else begin
                if (pos_reg < POS_W'(2)) begin
                    pos_next = pos_inc;
                end else if (pos_reg == POS_W'(2)) begin
                    plen_next = b;
                    if (b < 8'd3) begin
                        push.valid       = 1'b1;
                        push.cmd.verdict = 1'b1;
                        pos_next         = '0;
                    end else begin
                        sum_next  = '0;
                        held_next = '0;
                        pend_next = 1'b0;
                        pos_next  = POS_W'(3);
                    end
                end else if (pos_reg <= plen_ext) begin
                    sum_next  = t_sum;
                    held_next = t_held;
                    pend_next = t_pend;
                    pos_next  = pos_inc;
                end else if (pos_reg == plen_ext + POS_W'(1)) begin
                    rch_next = b;
                    pos_next = pos_inc;
                end else begin
                    push.valid       = 1'b1;
                    push.cmd.verdict = 1'b1;
                    push.cmd.ok      = ({rch_reg, b} == fin_cur);
                    pos_next         = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            held_reg <= '0;
            pend_reg <= 1'b0;
            pos_reg  <= '0;
            plen_reg <= '0;
            rch_reg  <= '0;
        end else begin
            sum_reg  <= sum_next;
            held_reg <= held_next;
            pend_reg <= pend_next;
            pos_reg  <= pos_next;
            plen_reg <= plen_next;
            rch_reg  <= rch_next;
        end
    end

endmodule

@@ rtl/rpfc_queue.sv @@
// ----------------------------------------------------------------------------
// rpfc_queue
// Short command queue between the front and back parts (DEPTH >= 2).
// ----------------------------------------------------------------------------
module rpfc_queue import rpfc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_push_t push,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output cmd_t      head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        do_push     = push.valid && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

@@ rtl/rpfc_back.sv @@
// ----------------------------------------------------------------------------
// rpfc_back
// Expands queued commands into result transactions, one per cycle while
// m_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module rpfc_back import rpfc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sync_cfg_t sync_cfg,
    input  logic      q_valid,
    input  cmd_t      q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t                 cur_reg, cur_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    logic                 have;
    logic [NUM_SLOTS-1:0] sel;
    logic                 last_slot;
    logic                 out_free;
    logic                 fire;
    out_item_t            item;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        have      = (mask_reg != '0);
        sel       = mask_reg & (~mask_reg + NUM_SLOTS'(1));
        last_slot = ((mask_reg & (mask_reg - NUM_SLOTS'(1))) == '0);
        out_free  = !out_valid_reg || m_ready;
        fire      = have && out_free;
        q_pop     = q_valid && (!have || (fire && last_slot));

        item = '0;
        case (sel)
            SLOT_HDR0:    item.out_byte = sync_cfg.sync_first;
            SLOT_HDR1:    item.out_byte = sync_cfg.sync_second;
            SLOT_HDR2:    item.out_byte = cur_reg.len_byte;
            SLOT_BODY:    item.out_byte = cur_reg.data;
            SLOT_CSUM_HI: item.out_byte = cur_reg.csum_val[15:8];
            SLOT_CSUM_LO: begin
                item.out_byte = cur_reg.csum_val[7:0];
                item.out_last = 1'b1;
            end
            SLOT_VERDICT: begin
                item.kind     = KIND_VERDICT;
                item.out_last = 1'b1;
                item.check_ok = cur_reg.ok;
            end
            default:      item = '0;
        endcase

        mask_next      = mask_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire) begin
            mask_next      = mask_reg & ~sel;
            out_valid_next = 1'b1;
            out_data_next  = item;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop) begin
            mask_next = cmd_mask(q_head);
            cur_next  = q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/rpfc_checker.sv @@
// ----------------------------------------------------------------------------
// rpfc_checker
// Port-level checks for the packet framer / checker, bound to the top level.
// ----------------------------------------------------------------------------
module rpfc_checker import rpfc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_verdict_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_VERDICT) |->
            (m_data.out_byte == 8'h00) && m_data.out_last)
        else $error("verdict with nonzero byte or without last");

    a_byte_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_BYTE) |-> !m_data.check_ok)
        else $error("framed byte carries check_ok");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind robot_packet_framer_checker rpfc_checker u_rpfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
